// ----- hdl/two_layer_mlp_inference_assert.svh -----
// Assertion macros for the MLP inference block.
`ifndef TWO_LAYER_MLP_INFERENCE_ASSERT_SVH
`define TWO_LAYER_MLP_INFERENCE_ASSERT_SVH
`ifndef SYNTHESIS
`define MLP_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MLP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define MLP_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MLP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- hdl/mlp_pkg.sv -----
`default_nettype none
package mlp_pkg;
    localparam int INPUTS_DEF     = 12288;
    localparam int HIDDEN_DEF     = 64;
    localparam int CLASSES_DEF    = 10;
    localparam int VALUE_BITS_DEF = 16;
    localparam int FRAC_BITS      = 12;

    localparam logic [2:0] OP_HW   = 3'd0;
    localparam logic [2:0] OP_HB   = 3'd1;
    localparam logic [2:0] OP_OW   = 3'd2;
    localparam logic [2:0] OP_OB   = 3'd3;
    localparam logic [2:0] OP_FEAT = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic [5:0]         hidden_index;
        logic [13:0]        element_index;
        logic signed [15:0] value;
        logic               end_of_vector;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         class_index;
        logic signed [47:0] score;
        logic               last_result;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FEAT, ST_ACT, ST_OUT, ST_EMIT
    } t_state;

    // Control from sequencer into the cell chain
    typedef struct packed {
        logic feat;     // shift a product into the chain
        logic act;      // shift an activation step
        logic clr;      // clear the accumulators
    } t_chain_ctl;

    localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
        logic signed [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47]) return s[48] ? ACC_MIN : ACC_MAX;
        return s[47:0];
    endfunction
endpackage
`default_nettype wire

// ----- hdl/mlp_cell.sv -----
`default_nettype none
// One hidden accumulator cell; passes its value along the chain on each shift.
module mlp_cell (
    input  wire logic               i_clk,
    input  wire mlp_pkg::t_chain_ctl i_ctl,
    input  wire logic signed [47:0] i_add,   // product for the cell at the head
    input  wire logic signed [47:0] i_prev,  // value of upstream cell
    input  wire logic               i_head,
    output logic signed [47:0]      o_acc
);
    logic signed [47:0] r_acc, n_acc;
    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clr) n_acc = '0;
        else if (i_ctl.feat || i_ctl.act)
            n_acc = i_head ? mlp_pkg::sat_add(i_prev, i_add) : i_prev;
    end
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end
    assign o_acc = r_acc;
endmodule
`default_nettype wire

// ----- hdl/two_layer_mlp_inference.sv -----
`default_nettype none
// Two-layer fully connected inference (ReLU hidden layer), fixed point Q3.12.
// Input channel: start with i_item; an item is taken when start is high and
// busy is low. Load items (ops 0..3) write a weight or bias store without
// raising busy, so loads can follow back to back. A feature item (op 4) holds
// busy until its multiply-accumulates are done: the hidden weight memory has
// one read port, so one multiply-accumulate runs per cycle, and the product
// enters a ring of HIDDEN accumulator cells that rotates one place per cycle;
// after HIDDEN rotations each sum is back at its own cell.
// A feature with end_of_vector then runs the activations and the output
// accumulation, class by class. Each score shows on o_result with o_valid
// high for one cycle, the last one marked by last_result. Busy stays high
// for the whole of such a pass. The receiver cannot stall.
// After the pass the sums clear.
// Reset (synchronous, active low) clears control state and, through a
// registered clear flag, all accumulators; weight stores are undefined until
// loaded. Memories: hidden weights HIDDEN*INPUTS entries, hidden bias HIDDEN,
// output weights HIDDEN*16, output bias 16, activations HIDDEN.
module two_layer_mlp_inference #(
    parameter int INPUTS     = mlp_pkg::INPUTS_DEF,
    parameter int HIDDEN     = mlp_pkg::HIDDEN_DEF,
    parameter int CLASSES    = mlp_pkg::CLASSES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire mlp_pkg::t_in_item i_item,
    output logic                   busy,
    output logic                   o_valid,
    output mlp_pkg::t_out_item     o_result
);
    localparam int VALUE_BITS = mlp_pkg::VALUE_BITS_DEF;
    localparam int FB = mlp_pkg::FRAC_BITS;
    localparam int HB = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
    localparam int IB = $clog2(INPUTS);
    localparam int AW = $clog2(HIDDEN * INPUTS);
    localparam int CB = 4;
    localparam int HC = HB + 1;   // counter wide enough to hold HIDDEN

    // ---------------- memories ----------------
    logic signed [15:0] m_hw [HIDDEN*INPUTS];
    logic signed [15:0] m_hb [HIDDEN];
    logic signed [15:0] m_ow [HIDDEN*16];
    logic signed [15:0] m_ob [16];
    logic signed [15:0] m_act [HIDDEN];

    mlp_pkg::t_state r_state, n_state;
    mlp_pkg::t_in_item r_item;
    logic [HC-1:0] r_h, n_h;          // hidden step counter
    logic [CB-1:0] r_c, n_c;          // class counter
    logic          r_eov;
    logic          r_clr;             // post-reset clear
    mlp_pkg::t_chain_ctl ctl;

    logic signed [15:0] r_wq, r_hbq, r_owq, r_obq, r_actq;
    logic signed [15:0] r_feat;
    logic signed [47:0] r_score;
    logic [HB-1:0]      r_rd_h;       // hidden index of read in flight

    wire [HB-1:0] h_idx = r_h[HB-1:0];
    wire load_ok_hw = (32'(i_item.hidden_index) < HIDDEN) &&
                      (32'(i_item.element_index) < INPUTS);
    wire feat_ok = 32'(r_item.element_index) < INPUTS;

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            unique case (i_item.operation)
                mlp_pkg::OP_HW: if (load_ok_hw)
                    m_hw[AW'(32'(i_item.hidden_index) * INPUTS +
                             32'(i_item.element_index))] <= i_item.value;
                mlp_pkg::OP_HB: if (32'(i_item.hidden_index) < HIDDEN)
                    m_hb[i_item.hidden_index[HB-1:0]] <= i_item.value;
                mlp_pkg::OP_OW: if (32'(i_item.hidden_index) < HIDDEN &&
                                    32'(i_item.element_index) < CLASSES)
                    m_ow[{i_item.hidden_index[HB-1:0], i_item.element_index[3:0]}]
                        <= i_item.value;
                mlp_pkg::OP_OB: if (32'(i_item.element_index) < CLASSES)
                    m_ob[i_item.element_index[3:0]] <= i_item.value;
                default: ;
            endcase
        end
        r_wq   <= m_hw[AW'(32'(h_idx) * INPUTS + 32'(r_item.element_index[IB-1:0]))];
        r_hbq  <= m_hb[h_idx];
        r_owq  <= m_ow[{h_idx, r_c}];
        r_obq  <= m_ob[n_c];          // bias of the class about to start
        r_actq <= m_act[h_idx];
        r_rd_h <= h_idx;
    end

    // ---------------- cell ring ----------------
    logic signed [47:0] acc [HIDDEN];
    logic signed [31:0] prod_f;
    logic signed [47:0] add_f;
    assign prod_f = r_feat * r_wq;
    assign add_f  = (ctl.feat && feat_ok) ? 48'(prod_f) : '0;

    for (genvar g = 0; g < HIDDEN; g++) begin : g_cell
        mlp_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (ctl),
            .i_add (add_f),
            .i_prev(acc[(g + HIDDEN - 1) % HIDDEN]),
            .i_head(g == 0),
            .o_acc (acc[g])
        );
    end

    // activation of the sum now at the ring tail (cell HIDDEN-1 feeds cell 0)
    logic signed [47:0] t_sum;
    logic signed [15:0] act_v;
    always_comb begin
        t_sum = mlp_pkg::sat_add(acc[HIDDEN-1], 48'(r_hbq) <<< FB);
        if (t_sum <= 0) act_v = '0;
        else if ((t_sum >>> FB) > 48'((1 << (VALUE_BITS - 1)) - 1))
            act_v = 16'((1 << (VALUE_BITS - 1)) - 1);
        else act_v = 16'(t_sum >>> FB);
    end
    always_ff @(posedge i_clk) begin
        if (ctl.act) m_act[r_rd_h] <= act_v;
    end

    // output MAC
    logic signed [31:0] prod_o;
    assign prod_o = r_actq * r_owq;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_h = r_h;
        n_c = r_c;
        unique case (r_state)
            mlp_pkg::ST_IDLE: begin
                n_h = '0;
                if (start && !busy && i_item.operation == mlp_pkg::OP_FEAT)
                    n_state = mlp_pkg::ST_FEAT;
            end
            mlp_pkg::ST_FEAT: begin
                n_h = r_h + 1'b1;
                if (r_h == HC'(HIDDEN)) begin
                    n_h = '0;
                    n_state = r_eov ? mlp_pkg::ST_ACT : mlp_pkg::ST_IDLE;
                end
            end
            mlp_pkg::ST_ACT: begin
                n_h = r_h + 1'b1;
                if (r_h == HC'(HIDDEN)) begin
                    n_h = '0; n_c = '0; n_state = mlp_pkg::ST_OUT;
                end
            end
            mlp_pkg::ST_OUT: begin
                n_h = r_h + 1'b1;
                if (r_h == HC'(HIDDEN)) n_state = mlp_pkg::ST_EMIT;
            end
            mlp_pkg::ST_EMIT: begin
                n_h = '0;
                n_c = r_c + 1'b1;
                n_state = (32'(r_c) == CLASSES - 1) ? mlp_pkg::ST_IDLE : mlp_pkg::ST_OUT;
            end
            default: n_state = mlp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.feat = (r_state == mlp_pkg::ST_FEAT) && (r_h != '0);
        ctl.act  = (r_state == mlp_pkg::ST_ACT) && (r_h != '0);
        ctl.clr  = r_clr || ((r_state == mlp_pkg::ST_EMIT) && (32'(r_c) == CLASSES - 1));
        busy     = (r_state != mlp_pkg::ST_IDLE) || r_clr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlp_pkg::ST_IDLE;
            r_h <= '0; r_c <= '0; r_clr <= 1'b1;
            o_valid <= 1'b0; r_eov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_h <= n_h; r_c <= n_c;
            r_clr <= 1'b0;
            o_valid <= (r_state == mlp_pkg::ST_EMIT);
            if (start && !busy) r_eov <= i_item.end_of_vector;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item <= i_item;
            r_feat <= i_item.value;
        end
        if (r_state == mlp_pkg::ST_OUT && r_h == '0)
            r_score <= 48'(r_obq) <<< FB;
        else if (r_state == mlp_pkg::ST_OUT)
            r_score <= mlp_pkg::sat_add(r_score, 48'(prod_o));
        if (r_state == mlp_pkg::ST_EMIT) begin
            o_result.class_index <= r_c;
            o_result.score       <= r_score;
            o_result.last_result <= (32'(r_c) == CLASSES - 1);
        end
    end

    wire w_emit      = (r_state == mlp_pkg::ST_EMIT);
    wire w_take_feat = start && !busy && (i_item.operation == mlp_pkg::OP_FEAT);

    `include "two_layer_mlp_inference_assert.svh"
    `MLP_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, w_emit, o_valid, "emit lost")
    `MLP_ASSERT_NEXT(a_busy_hold, i_clk, i_rst_n, w_take_feat, busy, "feature not busy")
    `MLP_ASSERT_IMPL(a_one_ctl, i_clk, i_rst_n, !(ctl.feat && ctl.act), "feat and act overlap")
endmodule
`default_nettype wire
